[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is held
`define ASSERT_IMPL(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, ck, rn, a, c)
`define ASSERT_NEXT(lbl, ck, rn, a, c)

`endif

`endif

[hw/rtl/fae_pkg.sv]
// ----------------------------------------------------------------------------
// fae_pkg
// Shared types and constants of the flash ADC event unpacker.
// ----------------------------------------------------------------------------
package fae_pkg;

  // Fixed result field widths
  localparam int WORD_W = 32;
  localparam int KIND_W = 2;
  localparam int CHAN_W = 3;
  localparam int IDX_W  = 12;
  localparam int SAMP_W = 16;
  localparam int MASK_W = 8;
  localparam int WPC_W  = 12;

  // Header words counted by the size field besides the payload
  localparam int HDR_ADJ = 4;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_PAIR    = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  // Control part of a queued request
  typedef struct packed {
    kind_t kind;
    logic  last;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);
  // Fixed part of a queue entry: command, payload word, board id, event number
  localparam int ENTRY_FIX_W = CMD_W + 3 * WORD_W;

  typedef struct packed {
    logic [WORD_W-1:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [CHAN_W-1:0]        adc_channel;
    logic [IDX_W-1:0]         pair_index;
    logic signed [SAMP_W-1:0] sample_low;
    logic signed [SAMP_W-1:0] sample_high;
    logic [WORD_W-1:0]        board_id;
    logic [WORD_W-1:0]        event_number;
    logic [MASK_W-1:0]        active_mask;
    logic [WPC_W-1:0]         words_per_channel;
    logic                     last;
  } out_item_t;

endpackage

[hw/rtl/fae_stream_if.sv]
// ----------------------------------------------------------------------------
// fae_stream_if
// Valid/ready stream channel carrying one request payload.
// ----------------------------------------------------------------------------
interface fae_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

[hw/rtl/fae_div.sv]
// ----------------------------------------------------------------------------
// fae_div
// Restoring divider, one quotient bit per cycle, for the per-channel count.
// ----------------------------------------------------------------------------
module fae_div #(
  parameter int DW = 12,
  parameter int VW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);

  localparam int CNTW = $clog2(DW + 1);

  logic            busy_r, busy_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]   quo_r, quo_nxt;
  logic [VW-1:0]   dvs_r, dvs_nxt;

  logic [VW:0] trial;
  logic [VW:0] diff;
  logic        ge;

  // One restoring step
  assign trial = {rem_r, quo_r[DW-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(DW);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[VW-1:0] : trial[VW-1:0];
      quo_nxt  = {quo_r[DW-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = cnt_r != CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

[hw/rtl/fae_front.sv]
// ----------------------------------------------------------------------------
// fae_front
// Header parser: latches header words, starts the count division, tracks
// payload progress and queues one request per result.
// ----------------------------------------------------------------------------
module fae_front #(
  parameter int N  = 8,
  parameter int SB = 12,
  parameter int CW = 4,
  parameter int EW = fae_pkg::ENTRY_FIX_W + N + SB
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fae_pkg::WORD_W-1:0]  in_word,
  output logic                        q_push,
  output logic [EW-1:0]               q_wdata,
  input  logic                        q_full,
  output logic                        div_start,
  output logic [SB-1:0]               div_dividend,
  output logic [CW-1:0]               div_divisor,
  input  logic                        div_busy,
  input  logic [SB-1:0]               div_quo
);

  typedef enum logic [5:0] {
    PH_BOARD   = 6'b000001,
    PH_SIZE    = 6'b000010,
    PH_MASK    = 6'b000100,
    PH_EVNUM   = 6'b001000,
    PH_SKIP    = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic [fae_pkg::WORD_W-1:0]   board_r, board_nxt;
  logic [SB-1:0]                size_r, size_nxt;
  logic [N-1:0]                 mask_r, mask_nxt;
  logic [fae_pkg::WORD_W-1:0]   evn_r, evn_nxt;
  logic [SB-1:0]                wpc_r, wpc_nxt;
  logic [SB-1:0]                wcnt_r, wcnt_nxt;
  logic [CW-1:0]                chleft_r, chleft_nxt;

  logic [N-1:0]                 word_mask;
  logic [CW-1:0]                pcount;
  logic                         accept;
  logic [SB-1:0]                wcnt_inc;
  logic                         chan_end;

  fae_pkg::cmd_t                e_cmd;
  logic [fae_pkg::WORD_W-1:0]   e_word;
  logic [fae_pkg::WORD_W-1:0]   e_bid;
  logic [fae_pkg::WORD_W-1:0]   e_evn;
  logic [N-1:0]                 e_mask;
  logic [SB-1:0]                e_wpc;

  // Active channel count of the incoming mask word
  assign word_mask = in_word[N-1:0];
  always_comb begin
    pcount = '0;
    for (int i = 0; i < N; i++) begin
      pcount = pcount + CW'(word_mask[i]);
    end
  end

  // Summary must wait for the quotient
  assign in_ready = !q_full && !((phase_r == PH_SKIP) && div_busy);
  assign accept   = in_valid && in_ready;

  assign wcnt_inc = wcnt_r + 1'b1;
  assign chan_end = wcnt_inc == wpc_r;

  assign div_dividend = (size_r < SB'(fae_pkg::HDR_ADJ)) ? '0 :
                        size_r - SB'(fae_pkg::HDR_ADJ);
  assign div_divisor  = pcount;

  // Parser state and request build
  always_comb begin
    phase_nxt  = phase_r;
    board_nxt  = board_r;
    size_nxt   = size_r;
    mask_nxt   = mask_r;
    evn_nxt    = evn_r;
    wpc_nxt    = wpc_r;
    wcnt_nxt   = wcnt_r;
    chleft_nxt = chleft_r;
    q_push     = 1'b0;
    div_start  = 1'b0;
    e_cmd      = '{kind: fae_pkg::KIND_PAIR, last: 1'b0};
    e_word     = '0;
    e_bid      = board_r;
    e_evn      = evn_r;
    e_mask     = mask_r;
    e_wpc      = wpc_r;
    if (accept) begin
      unique case (phase_r)
        PH_BOARD: begin
          board_nxt = in_word;
          phase_nxt = PH_SIZE;
        end
        PH_SIZE: begin
          size_nxt  = in_word[SB-1:0];
          phase_nxt = PH_MASK;
        end
        PH_MASK: begin
          if (pcount == '0) begin
            // Empty mask: report, then reuse this word as the next board id
            q_push    = 1'b1;
            e_cmd     = '{kind: fae_pkg::KIND_ERROR, last: 1'b1};
            e_evn     = '0;
            e_mask    = '0;
            e_wpc     = '0;
            board_nxt = in_word;
            mask_nxt  = '0;
            phase_nxt = PH_SIZE;
          end else begin
            mask_nxt   = word_mask;
            chleft_nxt = pcount;
            div_start  = 1'b1;
            phase_nxt  = PH_EVNUM;
          end
        end
        PH_EVNUM: begin
          evn_nxt   = in_word;
          phase_nxt = PH_SKIP;
        end
        PH_SKIP: begin
          q_push   = 1'b1;
          e_cmd    = '{kind: fae_pkg::KIND_SUMMARY, last: div_quo == '0};
          e_wpc    = div_quo;
          wpc_nxt  = div_quo;
          wcnt_nxt = '0;
          phase_nxt = (div_quo == '0) ? PH_BOARD : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          q_push = 1'b1;
          e_word = in_word;
          e_cmd  = '{kind: fae_pkg::KIND_PAIR,
                     last: chan_end && (chleft_r == CW'(1))};
          if (chan_end) begin
            wcnt_nxt   = '0;
            chleft_nxt = chleft_r - 1'b1;
            if (chleft_r == CW'(1)) begin
              phase_nxt = PH_BOARD;
            end
          end else begin
            wcnt_nxt = wcnt_inc;
          end
        end
        default: phase_nxt = PH_BOARD;
      endcase
    end
  end

  assign q_wdata = {e_cmd, e_word, e_bid, e_evn, e_mask, e_wpc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_BOARD;
      wcnt_r   <= '0;
      chleft_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      wcnt_r   <= wcnt_nxt;
      chleft_r <= chleft_nxt;
    end
  end

  always_ff @(posedge clk) begin
    board_r <= board_nxt;
    size_r  <= size_nxt;
    mask_r  <= mask_nxt;
    evn_r   <= evn_nxt;
    wpc_r   <= wpc_nxt;
  end

endmodule

[hw/rtl/fae_queue.sv]
// ----------------------------------------------------------------------------
// fae_queue
// Small register FIFO between parser and result stage. DEPTH is a power of two.
// ----------------------------------------------------------------------------
module fae_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = cnt_r == (AW + 1)'(DEPTH);
  assign valid   = cnt_r != '0;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Pointer and fill level update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[hw/rtl/fae_back.sv]
// ----------------------------------------------------------------------------
// fae_back
// Result stage: walks the active channels, numbers payload words and drives
// the registered result channel.
// ----------------------------------------------------------------------------
module fae_back #(
  parameter int N   = 8,
  parameter int SB  = 12,
  parameter int CHW = 3,
  parameter int EW  = fae_pkg::ENTRY_FIX_W + N + SB
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  logic [EW-1:0]       q_rdata,
  output logic                out_valid,
  input  logic                out_ready,
  output fae_pkg::out_item_t  out_data
);

  fae_pkg::cmd_t               e_cmd;
  logic [fae_pkg::WORD_W-1:0]  e_word;
  logic [fae_pkg::WORD_W-1:0]  e_bid;
  logic [fae_pkg::WORD_W-1:0]  e_evn;
  logic [N-1:0]                e_mask;
  logic [SB-1:0]               e_wpc;

  logic                        out_valid_r, out_valid_nxt;
  fae_pkg::out_item_t          out_data_r, out_data_nxt;
  logic [CHW-1:0]              ch_r, ch_nxt;
  logic [SB-1:0]               idx_r, idx_nxt;

  logic [CHW-1:0]              first_ch;
  logic [CHW-1:0]              above_ch;
  logic [SB-1:0]               idx_inc;

  assign {e_cmd, e_word, e_bid, e_evn, e_mask, e_wpc} = q_rdata;

  // Lowest active channel, and lowest active channel above the current one
  always_comb begin
    first_ch = '0;
    above_ch = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (e_mask[i]) begin
        first_ch = CHW'(i);
        if (CHW'(i) > ch_r) begin
          above_ch = CHW'(i);
        end
      end
    end
  end

  assign idx_inc = idx_r + 1'b1;
  assign q_pop   = q_valid && (!out_valid_r || out_ready);

  // Result formatting and channel walk
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ch_nxt        = ch_r;
    idx_nxt       = idx_r;
    if (q_pop) begin
      out_valid_nxt                   = 1'b1;
      out_data_nxt.kind               = e_cmd.kind;
      out_data_nxt.adc_channel        = '0;
      out_data_nxt.pair_index         = '0;
      out_data_nxt.sample_low         = '0;
      out_data_nxt.sample_high        = '0;
      out_data_nxt.board_id           = e_bid;
      out_data_nxt.event_number       = e_evn;
      out_data_nxt.active_mask        = fae_pkg::MASK_W'(e_mask);
      out_data_nxt.words_per_channel  = fae_pkg::WPC_W'(e_wpc);
      out_data_nxt.last               = e_cmd.last;
      unique case (e_cmd.kind)
        fae_pkg::KIND_SUMMARY: begin
          ch_nxt  = first_ch;
          idx_nxt = '0;
        end
        fae_pkg::KIND_PAIR: begin
          out_data_nxt.adc_channel = fae_pkg::CHAN_W'(ch_r);
          out_data_nxt.pair_index  = fae_pkg::IDX_W'(idx_r);
          out_data_nxt.sample_low  = $signed(e_word[fae_pkg::SAMP_W-1:0]);
          out_data_nxt.sample_high =
            $signed(e_word[fae_pkg::WORD_W-1:fae_pkg::SAMP_W]);
          if (idx_inc == e_wpc) begin
            idx_nxt = '0;
            ch_nxt  = above_ch;
          end else begin
            idx_nxt = idx_inc;
          end
        end
        fae_pkg::KIND_ERROR: begin
          ch_nxt = ch_r;
        end
        default: ch_nxt = ch_r;
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ch_r        <= '0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      ch_r        <= ch_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/flash_adc_event_unpacker.sv]
// ----------------------------------------------------------------------------
// flash_adc_event_unpacker
// Splits a digitizer event stream into a header summary, signed sample pairs
// per active channel, and zero-channel error reports.
// ----------------------------------------------------------------------------
//   channel   dir  payload     request
//   in_chan   in   in_item_t   one 32-bit stream word
//   out_chan  out  out_item_t  summary, sample pair or error result
//
// One word per cycle in header and payload phases while the queue has room.
// The per-channel count comes from a restoring divider, one bit per cycle,
// started at the mask word; the fifth header word waits for it. Each request
// passes through the two-entry queue and then the registered result stage.
// Reset is synchronous, active low, and leaves the parser expecting a board
// id. Either side may stall freely.
`include "assert_macros.svh"

module flash_adc_event_unpacker #(
  parameter int NUM_CHANNELS = 8,
  parameter int SIZE_BITS    = 12
) (
  input  logic           clk,
  input  logic           rst_n,
  fae_stream_if.sink     in_chan,
  fae_stream_if.source   out_chan
);

  localparam int CW      = $clog2(NUM_CHANNELS + 1);
  localparam int CHW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ENTRY_W = fae_pkg::ENTRY_FIX_W + NUM_CHANNELS + SIZE_BITS;
  localparam int Q_DEPTH = 2;

  logic                 q_push;
  logic [ENTRY_W-1:0]   q_wdata;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_valid;
  logic [ENTRY_W-1:0]   q_rdata;
  logic                 div_start;
  logic [SIZE_BITS-1:0] div_dividend;
  logic [CW-1:0]        div_divisor;
  logic                 div_busy;
  logic [SIZE_BITS-1:0] div_quo;
  fae_pkg::out_item_t   back_data;
  fae_pkg::cmd_t        push_cmd;

  fae_front #(
    .N  (NUM_CHANNELS),
    .SB (SIZE_BITS),
    .CW (CW),
    .EW (ENTRY_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .in_word      (in_chan.data.data_word),
    .q_push       (q_push),
    .q_wdata      (q_wdata),
    .q_full       (q_full),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_busy     (div_busy),
    .div_quo      (div_quo)
  );

  fae_div #(
    .DW (SIZE_BITS),
    .VW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  fae_queue #(
    .W     (ENTRY_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  fae_back #(
    .N   (NUM_CHANNELS),
    .SB  (SIZE_BITS),
    .CHW (CHW),
    .EW  (ENTRY_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_rdata   (q_rdata),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (back_data)
  );

  assign out_chan.data = back_data;

  // Command field of the request being queued
  assign push_cmd = fae_pkg::cmd_t'(q_wdata[ENTRY_W-1 -: fae_pkg::CMD_W]);

  // Checks
  `ASSERT_IMPL(a_queue_no_overflow, clk, rst_n, q_full, !q_push)
  `ASSERT_NEXT(a_div_runs_after_start, clk, rst_n, div_start, div_busy)
  `ASSERT_IMPL(a_error_ends_event, clk, rst_n,
               q_push && (push_cmd.kind == fae_pkg::KIND_ERROR), push_cmd.last)
  `ASSERT_IMPL(a_summary_after_quotient, clk, rst_n,
               q_push && (push_cmd.kind == fae_pkg::KIND_SUMMARY), !div_busy)

endmodule
